// File: src/lane_vehicle_count_accumulator_defines.svh
// ----------------------------------------------------------------------------
// Lane vehicle count accumulator: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef LANE_VEHICLE_COUNT_ACCUMULATOR_DEFINES_SVH
`define LANE_VEHICLE_COUNT_ACCUMULATOR_DEFINES_SVH

// Antecedent holds at an edge, consequent (property expression) must follow.
`define LVCA_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) \
    else $error(msg);

// Condition must never be seen outside reset.
`define LVCA_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error(msg);

`endif

// File: src/lvca_pkg.sv
// ----------------------------------------------------------------------------
// lvca_pkg
// Widths, register indexes and shared types of the lane volume accumulator.
// ----------------------------------------------------------------------------
package lvca_pkg;

  // field widths
  localparam int CODE_W  = 8;
  localparam int ID_W    = 16;
  localparam int COUNT_W = 16;
  localparam int IDX_W   = 3;
  localparam int DATA_W  = 16;

  // lane slots that have ID registers, and default number in use
  localparam int MAX_SLOTS = 4;
  localparam int LANES_DEF = 4;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_CODE_A = 3'd0;
  localparam logic [IDX_W-1:0] REG_CODE_B = 3'd1;
  localparam logic [IDX_W-1:0] REG_LANE_0 = 3'd2;
  localparam logic [IDX_W-1:0] REG_LANE_1 = 3'd3;
  localparam logic [IDX_W-1:0] REG_LANE_2 = 3'd4;
  localparam logic [IDX_W-1:0] REG_LANE_3 = 3'd5;

  // item modes
  localparam logic MODE_REPORT = 1'b0;
  localparam logic MODE_READ   = 1'b1;

  // volume limit
  localparam logic [COUNT_W-1:0] VOL_MAX = 16'hffff;

  // command broadcast to every lane slot
  typedef struct packed {
    logic               report;    // valid leave report
    logic               read;      // read and clear
    logic [ID_W-1:0]    lane_id;
    logic [COUNT_W-1:0] car_count;
  } lane_cmd_t;

endpackage

// File: src/lvca_lane.sv
// ----------------------------------------------------------------------------
// lvca_lane
// One lane slot: last reported count and accumulated volume, updated by a
// leave report or cleared by a read when the slot ID matches.
// ----------------------------------------------------------------------------
module lvca_lane (
  input  logic                             clk,
  input  logic                             rst,
  input  lvca_pkg::lane_cmd_t              cmd,
  input  logic [lvca_pkg::ID_W-1:0]        slot_id,
  output logic                             hit,
  output logic [lvca_pkg::COUNT_W-1:0]     volume
);
  import lvca_pkg::*;

  logic [COUNT_W-1:0] last_count;
  logic [COUNT_W-1:0] lane_volume;
  logic [COUNT_W-1:0] amount;
  logic [COUNT_W:0]   sum;
  logic [COUNT_W-1:0] volume_next;

  assign hit    = (cmd.lane_id == slot_id);
  assign volume = lane_volume;

  // increase: first report counts one, a drop uses the wrap form
  always_comb begin
    if (last_count == '0) begin
      amount = COUNT_W'(1);
    end else if (cmd.car_count >= last_count) begin
      amount = cmd.car_count - last_count;
    end else begin
      amount = cmd.car_count + ~last_count;   // 0xffff - last + count
    end
    sum         = {1'b0, lane_volume} + {1'b0, amount};
    volume_next = sum[COUNT_W] ? VOL_MAX : sum[COUNT_W-1:0];
  end

  // slot state
  always_ff @(posedge clk) begin
    if (rst) begin
      last_count  <= '0;
      lane_volume <= '0;
    end else if (hit && cmd.report) begin
      last_count  <= cmd.car_count;
      lane_volume <= volume_next;
    end else if (hit && cmd.read) begin
      lane_volume <= '0;
    end
  end

endmodule

// File: src/lane_vehicle_count_accumulator.sv
// ----------------------------------------------------------------------------
// lane_vehicle_count_accumulator
// Per-lane traffic volume from running sensor vehicle counts.
// ----------------------------------------------------------------------------
// Takes one item per clock: busy stays low, so a start is accepted in every
// cycle. An item is captured in the input register, then the lane slots are
// compared and updated in the following cycle, and the result is presented
// with a one-cycle done strobe by the result register, loaded together with
// the slots; the receiver cannot stall, so volume must be taken in the cycle
// done is high. A report (mode 0) always answers volume 0; a read (mode 1)
// answers the volume of the highest-numbered matching slot, or 0, and clears
// every matching slot. Configuration writes are always ready and belong
// between items.
module lane_vehicle_count_accumulator #(
  parameter int LANES = lvca_pkg::LANES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // item channel
  input  logic                             start,
  output logic                             busy,
  input  logic                             mode,
  input  logic [lvca_pkg::CODE_W-1:0]      packet_type,
  input  logic [lvca_pkg::ID_W-1:0]        lane_id,
  input  logic [lvca_pkg::COUNT_W-1:0]     car_count,
  // result
  output logic                             done,
  output logic [lvca_pkg::COUNT_W-1:0]     volume,
  // configuration
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [lvca_pkg::IDX_W-1:0]       cfg_index,
  input  logic [lvca_pkg::DATA_W-1:0]      cfg_data
);
  import lvca_pkg::*;

  logic                 in_valid;
  logic                 in_mode;
  logic [CODE_W-1:0]    in_type;
  logic [ID_W-1:0]      in_id;
  logic [COUNT_W-1:0]   in_count;

  logic [CODE_W-1:0]    leave_code_a;
  logic [CODE_W-1:0]    leave_code_b;
  logic [ID_W-1:0]      slot_id [MAX_SLOTS];

  lane_cmd_t            cmd;
  logic [LANES-1:0]     hit;
  logic [COUNT_W-1:0]   lane_vol [LANES];
  logic [COUNT_W-1:0]   volume_next;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      leave_code_a <= '0;
      leave_code_b <= '0;
      for (int i = 0; i < MAX_SLOTS; i++) begin
        slot_id[i] <= '0;
      end
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CODE_A: leave_code_a <= cfg_data[CODE_W-1:0];
        REG_CODE_B: leave_code_b <= cfg_data[CODE_W-1:0];
        REG_LANE_0: slot_id[0]   <= cfg_data[ID_W-1:0];
        REG_LANE_1: slot_id[1]   <= cfg_data[ID_W-1:0];
        REG_LANE_2: slot_id[2]   <= cfg_data[ID_W-1:0];
        REG_LANE_3: slot_id[3]   <= cfg_data[ID_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_mode  <= mode;
      in_type  <= packet_type;
      in_id    <= lane_id;
      in_count <= car_count;
    end
  end

  // lane command: only leave packets update
  always_comb begin
    cmd.report    = in_valid && (in_mode == MODE_REPORT) &&
                    ((in_type == leave_code_a) || (in_type == leave_code_b));
    cmd.read      = in_valid && (in_mode == MODE_READ);
    cmd.lane_id   = in_id;
    cmd.car_count = in_count;
  end

  // lane slots
  for (genvar g = 0; g < LANES; g++) begin : g_lane
    lvca_lane u_lane (
      .clk     (clk),
      .rst     (rst),
      .cmd     (cmd),
      .slot_id (slot_id[g]),
      .hit     (hit[g]),
      .volume  (lane_vol[g])
    );
  end

  // read select: highest matching slot wins
  always_comb begin
    volume_next = '0;
    if (in_mode == MODE_READ) begin
      for (int i = 0; i < LANES; i++) begin
        if (hit[i]) begin
          volume_next = lane_vol[i];
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      volume <= volume_next;
    end
  end

endmodule

// File: src/lvca_checker.sv
// ----------------------------------------------------------------------------
// lvca_checker
// Port-level checks of the lane volume accumulator, bound to the top level.
// ----------------------------------------------------------------------------
`include "lane_vehicle_count_accumulator_defines.svh"

module lvca_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic                             busy,
  input  logic                             mode,
  input  logic                             done,
  input  logic [lvca_pkg::COUNT_W-1:0]     volume
);
  import lvca_pkg::*;

  // every accepted item is answered with a done strobe
  `LVCA_ASSERT_IMPLY(a_done_follows, start && !busy, ##2 done, "missing result")

  // no result without an accepted item
  `LVCA_ASSERT_IMPLY(a_no_spurious, done, $past(start && !busy, 2), "spurious result")

  // a report always answers volume zero
  `LVCA_ASSERT_IMPLY(a_report_zero, done && $past(start && !busy && mode == MODE_REPORT, 2),
    volume == '0, "report returned nonzero volume")

  // items are never refused
  `LVCA_ASSERT_NEVER(a_never_busy, busy, "busy raised")

endmodule

bind lane_vehicle_count_accumulator lvca_checker u_lvca_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .mode   (mode),
  .done   (done),
  .volume (volume)
);

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lane vehicle count accumulator testbench
// Drives sensor reports and read-and-clear commands through the start/busy
// channel and predicts every volume with its own per-slot copy of the count
// and volume state. Directed checks of the first-report, wrap, equal-count,
// saturation, shared-ID and no-match cases come first. Random phases follow,
// each under a new lane setup, with the sender idling at different rates.
// ----------------------------------------------------------------------------
module testbench;
  import lvca_pkg::*;

  // counts go down across this base when a sensor counter wraps
  localparam logic [COUNT_W-1:0] WRAP_BASE = 16'hffff;
  // indexes past the last register; writes there must change nothing
  localparam logic [IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [IDX_W-1:0] REG_SPARE_B = 3'd7;
  localparam int PHASES = 6;
  localparam int PHASE_ITEMS = 235;

  // --------------------------------------------------------------------------
  // Volume predictor and queue of expected volumes
  // --------------------------------------------------------------------------
  class volume_tracker;
    logic [CODE_W-1:0]  code_a;
    logic [CODE_W-1:0]  code_b;
    logic [ID_W-1:0]    slot_id     [MAX_SLOTS];
    logic [COUNT_W-1:0] last_count  [MAX_SLOTS];
    logic [COUNT_W-1:0] slot_volume [MAX_SLOTS];
    logic [COUNT_W-1:0] expected_volume [$];
    int errors;

    function new();
      code_a = '0;
      code_b = '0;
      errors = 0;
      for (int s = 0; s < MAX_SLOTS; s++) begin
        slot_id[s] = '0;
        last_count[s] = '0;
        slot_volume[s] = '0;
      end
    endfunction

    function void set_register(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] data);
      case (idx)
        REG_CODE_A: code_a = data[CODE_W-1:0];
        REG_CODE_B: code_b = data[CODE_W-1:0];
        REG_LANE_0: slot_id[0] = data[ID_W-1:0];
        REG_LANE_1: slot_id[1] = data[ID_W-1:0];
        REG_LANE_2: slot_id[2] = data[ID_W-1:0];
        REG_LANE_3: slot_id[3] = data[ID_W-1:0];
        default: ;
      endcase
    endfunction

    // saturating add into one slot
    function void add_volume(int s, logic [COUNT_W:0] amount);
      logic [COUNT_W:0] sum;
      sum = {1'b0, slot_volume[s]} + amount;
      slot_volume[s] = sum[COUNT_W] ? VOL_MAX : sum[COUNT_W-1:0];
    endfunction

    // accepted item: update state, queue the volume it must answer
    function void note_item(logic m, logic [CODE_W-1:0] ptype, logic [ID_W-1:0] id,
                            logic [COUNT_W-1:0] cnt);
      logic [COUNT_W-1:0] answer;
      answer = '0;
      if (m == MODE_REPORT) begin
        if (ptype == code_a || ptype == code_b) begin
          for (int s = 0; s < LANES_DEF; s++) begin
            if (slot_id[s] == id) begin
              if (last_count[s] == '0) begin
                // first report of this slot
                last_count[s] = cnt;
                add_volume(s, 17'd1);
              end else if (cnt > last_count[s]) begin
                add_volume(s, {1'b0, cnt - last_count[s]});
                last_count[s] = cnt;
              end else if (cnt < last_count[s]) begin
                // counter wrapped
                add_volume(s, {1'b0, WRAP_BASE - last_count[s]} + {1'b0, cnt});
                last_count[s] = cnt;
              end
            end
          end
        end
      end else begin
        // highest matching slot wins, every match is cleared
        for (int s = 0; s < LANES_DEF; s++) begin
          if (slot_id[s] == id) begin
            answer = slot_volume[s];
            slot_volume[s] = '0;
          end
        end
      end
      expected_volume.push_back(answer);
    endfunction

    function void check_volume(logic [COUNT_W-1:0] got);
      logic [COUNT_W-1:0] want;
      if (expected_volume.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: volume %0d with no item outstanding", $realtime, got);
      end else begin
        want = expected_volume.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10)
            $display("%0t: volume mismatch, expected %0d, got %0d", $realtime, want, got);
        end
      end
    endfunction
  endclass

  typedef struct packed {
    logic [CODE_W-1:0]                 code_a;
    logic [CODE_W-1:0]                 code_b;
    logic [MAX_SLOTS-1:0][ID_W-1:0]    ids;
  } lane_setup_t;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic               mode;
  logic [CODE_W-1:0]  packet_type;
  logic [ID_W-1:0]    lane_id;
  logic [COUNT_W-1:0] car_count;
  logic               done;
  logic [COUNT_W-1:0] volume;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [IDX_W-1:0]   cfg_index;
  logic [DATA_W-1:0]  cfg_data;

  volume_tracker tracker = new();
  lane_setup_t   cur_setup;
  logic [COUNT_W-1:0] sensor_count [MAX_SLOTS];

  lane_vehicle_count_accumulator dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .mode        (mode),
    .packet_type (packet_type),
    .lane_id     (lane_id),
    .car_count   (car_count),
    .done        (done),
    .volume      (volume),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("[lane_vehicle_count_accumulator] ERROR");
    $finish;
  end

  // observe transfers at each edge
  always @(posedge clk) begin
    if (!rst) begin
      if (done)
        tracker.check_volume(volume);
      if (cfg_valid && cfg_ready)
        tracker.set_register(cfg_index, cfg_data);
      if (start && !busy)
        tracker.note_item(mode, packet_type, lane_id, car_count);
    end
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  // one item transfer; start stays high for a following item
  task automatic send_item(input logic m, input logic [CODE_W-1:0] ptype,
                           input logic [ID_W-1:0] id, input logic [COUNT_W-1:0] cnt);
    start       <= 1'b1;
    mode        <= m;
    packet_type <= ptype;
    lane_id     <= id;
    car_count   <= cnt;
    do @(posedge clk); while (busy);
  endtask

  // sender gap with junk on the fields
  task automatic pause_items(input int n);
    start       <= 1'b0;
    mode        <= 1'($urandom);
    packet_type <= CODE_W'($urandom);
    lane_id     <= ID_W'($urandom);
    car_count   <= COUNT_W'($urandom);
    repeat (n) @(posedge clk);
  endtask

  // one register transfer; caller lowers valid after the last one
  task automatic send_config(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // stop items and wait for every outstanding volume
  task automatic drain_items();
    start <= 1'b0;
    @(posedge clk);
    while (tracker.expected_volume.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic load_setup(input lane_setup_t su);
    drain_items();
    send_config(REG_CODE_A, DATA_W'(su.code_a));
    send_config(REG_CODE_B, DATA_W'(su.code_b));
    send_config(REG_LANE_0, su.ids[0]);
    send_config(REG_LANE_1, su.ids[1]);
    send_config(REG_LANE_2, su.ids[2]);
    send_config(REG_LANE_3, su.ids[3]);
    if ($urandom_range(0, 1) == 1)
      send_config($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, DATA_W'($urandom));
    cfg_valid <= 1'b0;
    cur_setup = su;
  endtask

  // lane setups: extremes first, then equal codes, all-shared IDs, random
  function automatic lane_setup_t make_setup(input int ph);
    lane_setup_t su;
    su.code_a = CODE_W'($urandom);
    su.code_b = CODE_W'($urandom);
    for (int s = 0; s < MAX_SLOTS; s++) begin
      su.ids[s] = ID_W'($urandom);
      if (s > 0 && $urandom_range(0, 99) < 30)
        su.ids[s] = su.ids[s-1];
    end
    case (ph)
      0: begin
        su.code_a = '0;
        su.code_b = '1;
        su.ids = {16'h0000, 16'hffff, 16'h0000, 16'hffff};
      end
      1: su.code_b = su.code_a;
      2: begin
        su.code_a = '1;
        su.code_b = '0;
        su.ids = {4{16'hffff}};
      end
      default: ;
    endcase
    return su;
  endfunction

  // mostly well-formed reports and reads on configured lanes, some noise
  task automatic send_random_item();
    int kind;
    int slot;
    int pick;
    logic [ID_W-1:0] id;
    logic [CODE_W-1:0] ptype;
    logic [COUNT_W-1:0] cnt;
    kind = $urandom_range(0, 99);
    slot = $urandom_range(0, MAX_SLOTS - 1);
    ptype = CODE_W'($urandom);
    cnt = COUNT_W'($urandom);
    id = ($urandom_range(0, 99) < 90) ? cur_setup.ids[slot] : ID_W'($urandom);
    if (kind < 10) begin
      send_item(1'($urandom), ptype, ID_W'($urandom), cnt);
    end else if (kind < 35) begin
      send_item(MODE_READ, ptype, id, cnt);
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 60)
        ptype = cur_setup.code_a;
      else if (pick < 85)
        ptype = cur_setup.code_b;
      pick = $urandom_range(0, 99);
      if (pick < 60)
        cnt = sensor_count[slot] + COUNT_W'($urandom_range(0, 5));
      else if (pick < 70)
        cnt = sensor_count[slot];
      else if (pick < 80)
        cnt = sensor_count[slot] - COUNT_W'($urandom_range(1, 3));
      else if (pick < 90)
        cnt = '0;
      sensor_count[slot] = cnt;
      send_item(MODE_REPORT, ptype, id, cnt);
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    lane_setup_t su;
    int idle_pct;
    int wait_cnt;

    rst         = 1'b1;
    start       = 1'b0;
    mode        = MODE_REPORT;
    packet_type = '0;
    lane_id     = '0;
    car_count   = '0;
    cfg_valid   = 1'b0;
    cfg_index   = REG_CODE_A;
    cfg_data    = '0;
    for (int s = 0; s < MAX_SLOTS; s++) sensor_count[s] = '0;
    cur_setup = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset setup: codes and IDs all zero, so every slot shares ID 0
    send_item(MODE_REPORT, 8'h00, 16'h0000, 16'h0000);   // first report, count 0
    send_item(MODE_REPORT, 8'h00, 16'h0000, 16'h0000);   // still a first report
    send_item(MODE_READ,   8'h00, 16'h0000, 16'h0000);   // highest slot answers

    su.code_a = 8'hff;
    su.code_b = 8'h00;
    su.ids = {16'h1234, 16'h1234, 16'hffff, 16'h0000};
    load_setup(su);
    send_item(MODE_REPORT, 8'hff, 16'hffff, 16'hffff);   // first report at top count
    send_item(MODE_REPORT, 8'h00, 16'hffff, 16'h0000);   // wrap that adds nothing
    send_item(MODE_READ,   8'h00, 16'hffff, 16'h0000);
    send_item(MODE_REPORT, 8'h7e, 16'h1234, 16'h0005);   // not a leave code
    send_item(MODE_READ,   8'hff, 16'h1234, 16'hffff);
    send_item(MODE_REPORT, 8'hff, 16'h1234, 16'h0001);   // shared ID, both slots
    send_item(MODE_REPORT, 8'hff, 16'h1234, 16'h000a);   // count goes up
    send_item(MODE_REPORT, 8'hff, 16'h1234, 16'h000a);   // count unchanged
    send_item(MODE_REPORT, 8'h00, 16'h1234, 16'h0000);   // wrap up to the limit
    send_item(MODE_REPORT, 8'hff, 16'h1234, 16'h0003);   // saturates
    send_item(MODE_READ,   8'h00, 16'h1234, 16'h0000);
    send_item(MODE_READ,   8'h00, 16'habcd, 16'h0000);   // no matching slot
    send_item(MODE_REPORT, 8'hff, 16'h0000, 16'hffff);
    send_item(MODE_READ,   8'hff, 16'h0000, 16'hffff);   // report fields ignored
    send_item(MODE_REPORT, 8'h5a, 16'h0000, 16'h0001);   // ignored
    send_item(MODE_READ,   8'h00, 16'h0000, 16'h0000);

    // random phases, each under its own lane setup
    for (int ph = 0; ph < PHASES; ph++) begin
      load_setup(make_setup(ph));
      idle_pct = (ph % 3 == 1) ? 61 : ((ph % 3 == 2) ? 17 : 0);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_random_item();
        // quiet window inside idling phases
        if ((n < 100 || n >= 140) && $urandom_range(0, 99) < idle_pct)
          pause_items($urandom_range(1, 4));
      end
    end

    // let the pipeline empty
    start <= 1'b0;
    @(posedge clk);
    wait_cnt = 0;
    while (tracker.expected_volume.size() != 0 && wait_cnt < 100) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (5) @(posedge clk);
    if (tracker.expected_volume.size() != 0)
      $display("%0d volumes never arrived", tracker.expected_volume.size());

    if (tracker.errors == 0 && tracker.expected_volume.size() == 0)
      $display("[lane_vehicle_count_accumulator] OK");
    else
      $display("[lane_vehicle_count_accumulator] ERROR");
    $finish;
  end

endmodule

// File: sim.f
+incdir+src
src/lvca_pkg.sv
src/lvca_lane.sv
src/lane_vehicle_count_accumulator.sv
src/lvca_checker.sv
tb/testbench.sv
